// File: rtl/core/sccbm_pkg.sv
`timescale 1ns / 1ps
// sccbm_pkg: phase codes, command/mode/status codes and the shared structs
// for the SCCB register master. No dependencies.
package sccbm_pkg;

  // bus phase codes
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_CHECK      = 4'd1;
  localparam logic [3:0] PH_START      = 4'd2;
  localparam logic [3:0] PH_START_HOLD = 4'd3;
  localparam logic [3:0] PH_BIT_LOW    = 4'd4;
  localparam logic [3:0] PH_BIT_HIGH   = 4'd5;
  localparam logic [3:0] PH_ACK_LOW    = 4'd6;
  localparam logic [3:0] PH_ACK_HIGH   = 4'd7;
  localparam logic [3:0] PH_RD_LOW     = 4'd8;
  localparam logic [3:0] PH_RD_HIGH    = 4'd9;
  localparam logic [3:0] PH_MACK_LOW   = 4'd10;
  localparam logic [3:0] PH_MACK_HIGH  = 4'd11;
  localparam logic [3:0] PH_STOP1      = 4'd12;
  localparam logic [3:0] PH_STOP2      = 4'd13;
  localparam logic [3:0] PH_STOP3      = 4'd14;

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // transaction modes
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_W8   = 2'd1;
  localparam logic [1:0] MODE_W16  = 2'd2;
  localparam logic [1:0] MODE_RD   = 2'd3;

  // completion status
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BUS_BUSY = 2'd1;
  localparam logic [1:0] STAT_NACK     = 2'd2;

  // byte stages on the bus
  localparam logic [1:0] STG_ADDR   = 2'd0;
  localparam logic [1:0] STG_OFFSET = 2'd1;
  localparam logic [1:0] STG_SECOND = 2'd2;
  localparam logic [1:0] STG_THIRD  = 2'd3;

  // register map
  localparam logic [2:0] ADDR_SLAVE = 3'd0;

  localparam logic [3:0] BYTE_BITS = 4'd8;

  typedef struct packed {
    logic [3:0]  phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [7:0]  held_offset;
    logic [15:0] held_data;
    logic [1:0]  held_mode;
    logic [1:0]  error_code;
    logic [1:0]  stage;
  } state_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       busy;
    logic       done;
    logic [1:0] status;
  } result_t;

endpackage

// File: rtl/core/sccb_register_master_core.sv
`timescale 1ns / 1ps
// sccb_register_master_core: SCCB/I2C register master, one bus phase per item.
// A result is on the output in the cycle after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; the phase step is a single registered pass.
// Reset (rst_ni low, asynchronous): phase idle, all held state cleared,
// slave address 33, output register empty.
// Depends on sccbm_pkg and sccbm_step.
module sccb_register_master_core #(
  parameter int MAX_BURST = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // item input: one bus phase tick
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  reg_offset_i,
  input  logic [15:0] write_data_i,
  input  logic        write_two_i,
  input  logic [8:0]  read_count_i,
  input  logic        sda_sample_i,

  // item output: pin levels and status for that tick
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_release_o,
  output logic        sda_release_o,
  output logic [7:0]  read_byte_o,
  output logic        byte_valid_o,
  output logic        last_byte_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [1:0]  status_o
);
  import sccbm_pkg::*;

  // bytes_left must hold MAX_BURST itself
  localparam int BL_W = $clog2(MAX_BURST + 1);

  logic [6:0]      slave_addr_q;
  state_t          state_q, state_d;
  logic [BL_W-1:0] bytes_left_q, bytes_left_d;
  logic [BL_W-1:0] count_clamped;
  result_t         res_d, result_q;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration: one register, slave address at byte address 0.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr == ADDR_SLAVE) ? {25'd0, slave_addr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_addr_q <= 7'd33;
    end else if (cfg_wr && paddr == ADDR_SLAVE) begin
      slave_addr_q <= pwdata[6:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: the output register parts the two sides. A new item is taken
  // whenever the output register is empty or being drained this cycle.
  // ---------------------------------------------------------------------------
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  // burst length clamped to MAX_BURST
  assign count_clamped = (32'(read_count_i) > 32'(MAX_BURST)) ?
                         BL_W'(MAX_BURST) : BL_W'(read_count_i);

  sccbm_step #(
    .BL_W (BL_W)
  ) u_step (
    .state_i         (state_q),
    .bytes_left_i    (bytes_left_q),
    .slave_address_i (slave_addr_q),
    .cmd_i           (cmd_i),
    .reg_offset_i    (reg_offset_i),
    .write_data_i    (write_data_i),
    .write_two_i     (write_two_i),
    .read_count_i    (count_clamped),
    .sda_sample_i    (sda_sample_i),
    .state_o         (state_d),
    .bytes_left_o    (bytes_left_d),
    .result_o        (res_d)
  );

  // phase state advances only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      bytes_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q      <= state_d;
        bytes_left_q <= bytes_left_d;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign scl_release_o = result_q.scl_release;
  assign sda_release_o = result_q.sda_release;
  assign read_byte_o   = result_q.read_byte;
  assign byte_valid_o  = result_q.byte_valid;
  assign last_byte_o   = result_q.last_byte;
  assign busy_res_o    = result_q.busy;
  assign done_res_o    = result_q.done;
  assign status_o      = result_q.status;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // busy flag in the result matches the phase left behind by that item
  a_busy_tracks_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_q && (result_q.busy == (state_q.phase != PH_IDLE))))
    else $error("busy flag disagrees with phase");

  // a finished transaction leaves the master idle
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.done) |-> !result_q.busy)
    else $error("done while still busy");

  // an error status only comes with done
  a_status_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.status != STAT_OK) |-> result_q.done)
    else $error("status without done");

  // received bytes only arrive mid-transaction, last marks a received byte
  a_byte_in_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && result_q.last_byte) |-> (result_q.byte_valid && result_q.busy))
    else $error("last byte outside a read");

  // accepted items never overwrite a stalled result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !accept)
    else $error("item taken while result stalled");

endmodule

// File: rtl/core/sccbm_step.sv
`timescale 1ns / 1ps
// sccbm_step: one bus-phase step of the SCCB master, purely combinational.
// Depends on sccbm_pkg.
module sccbm_step #(
  parameter int BL_W = 9
) (
  input  sccbm_pkg::state_t  state_i,
  input  logic [BL_W-1:0]    bytes_left_i,
  input  logic [6:0]         slave_address_i,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         reg_offset_i,
  input  logic [15:0]        write_data_i,
  input  logic               write_two_i,
  input  logic [BL_W-1:0]    read_count_i,   // already clamped
  input  logic               sda_sample_i,
  output sccbm_pkg::state_t  state_o,
  output logic [BL_W-1:0]    bytes_left_o,
  output sccbm_pkg::result_t result_o
);
  import sccbm_pkg::*;

  logic [3:0]      bc_dec;
  logic [7:0]      rd_shift;
  logic [BL_W-1:0] bl_dec;
  logic            last_rd;

  assign bc_dec   = state_i.bit_count - 4'd1;
  assign rd_shift = {state_i.shift_reg[6:0], sda_sample_i};
  assign bl_dec   = (bytes_left_i != '0) ? bytes_left_i - BL_W'(1) : bytes_left_i;
  assign last_rd  = (bytes_left_i <= BL_W'(1));

  always_comb begin
    state_o      = state_i;
    bytes_left_o = bytes_left_i;
    result_o     = '0;
    result_o.scl_release = 1'b1;
    result_o.sda_release = 1'b1;

    unique case (state_i.phase)
      PH_IDLE: begin
        if (cmd_i == CMD_WRITE || cmd_i == CMD_READ) begin
          state_o.held_offset = reg_offset_i;
          state_o.held_data   = write_data_i;
          if (cmd_i == CMD_WRITE) begin
            state_o.held_mode = write_two_i ? MODE_W16 : MODE_W8;
            bytes_left_o      = '0;
          end else begin
            state_o.held_mode = MODE_RD;
            bytes_left_o      = read_count_i;
          end
          state_o.error_code = STAT_OK;
          state_o.stage      = STG_ADDR;
          state_o.phase      = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (!sda_sample_i) begin
          result_o.done   = 1'b1;
          result_o.status = STAT_BUS_BUSY;
          state_o.phase   = PH_IDLE;
        end else begin
          state_o.phase = PH_START;
        end
      end
      PH_START: begin
        result_o.sda_release = 1'b0;
        state_o.phase        = PH_START_HOLD;
      end
      PH_START_HOLD: begin
        result_o.scl_release = 1'b0;
        result_o.sda_release = 1'b0;
        if (sda_sample_i) begin
          result_o.done   = 1'b1;
          result_o.status = STAT_BUS_BUSY;
          state_o.phase   = PH_IDLE;
        end else begin
          state_o.shift_reg = {slave_address_i, state_i.stage == STG_SECOND};
          state_o.bit_count = BYTE_BITS;
          state_o.phase     = PH_BIT_LOW;
        end
      end
      PH_BIT_LOW: begin
        result_o.scl_release = 1'b0;
        result_o.sda_release = state_i.shift_reg[7];
        state_o.phase        = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        result_o.sda_release = state_i.shift_reg[7];
        state_o.shift_reg    = {state_i.shift_reg[6:0], 1'b0};
        state_o.bit_count    = bc_dec;
        state_o.phase        = (bc_dec == 4'd0) ? PH_ACK_LOW : PH_BIT_LOW;
      end
      PH_ACK_LOW: begin
        result_o.scl_release = 1'b0;
        state_o.phase        = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        priority if (sda_sample_i) begin
          state_o.error_code = STAT_NACK;
          state_o.phase      = PH_STOP1;
        end else if (state_i.stage == STG_ADDR) begin
          state_o.stage     = STG_OFFSET;
          state_o.shift_reg = state_i.held_offset;
          state_o.bit_count = BYTE_BITS;
          state_o.phase     = PH_BIT_LOW;
        end else if (state_i.held_mode == MODE_RD) begin
          if (state_i.stage == STG_OFFSET) begin
            // offset sent: stop, then restart for the read address
            state_o.stage = STG_SECOND;
            state_o.phase = PH_STOP1;
          end else begin
            state_o.stage     = STG_THIRD;
            state_o.bit_count = BYTE_BITS;
            state_o.shift_reg = '0;
            state_o.phase     = (bytes_left_i == '0) ? PH_STOP1 : PH_RD_LOW;
          end
        end else if (state_i.stage == STG_OFFSET) begin
          state_o.stage     = STG_SECOND;
          state_o.shift_reg = (state_i.held_mode == MODE_W16) ?
                              state_i.held_data[15:8] : state_i.held_data[7:0];
          state_o.bit_count = BYTE_BITS;
          state_o.phase     = PH_BIT_LOW;
        end else if (state_i.stage == STG_SECOND && state_i.held_mode == MODE_W16) begin
          state_o.stage     = STG_THIRD;
          state_o.shift_reg = state_i.held_data[7:0];
          state_o.bit_count = BYTE_BITS;
          state_o.phase     = PH_BIT_LOW;
        end else begin
          state_o.phase = PH_STOP1;
        end
      end
      PH_RD_LOW: begin
        result_o.scl_release = 1'b0;
        state_o.phase        = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        state_o.shift_reg = rd_shift;
        state_o.bit_count = bc_dec;
        if (bc_dec == 4'd0) begin
          result_o.byte_valid = 1'b1;
          result_o.read_byte  = rd_shift;
          result_o.last_byte  = (bytes_left_i == BL_W'(1));
          state_o.phase       = PH_MACK_LOW;
        end else begin
          state_o.phase = PH_RD_LOW;
        end
      end
      PH_MACK_LOW: begin
        result_o.scl_release = 1'b0;
        result_o.sda_release = last_rd;
        state_o.phase        = PH_MACK_HIGH;
      end
      PH_MACK_HIGH: begin
        result_o.sda_release = last_rd;
        bytes_left_o         = bl_dec;
        if (bl_dec == '0) begin
          state_o.phase = PH_STOP1;
        end else begin
          state_o.bit_count = BYTE_BITS;
          state_o.shift_reg = '0;
          state_o.phase     = PH_RD_LOW;
        end
      end
      PH_STOP1: begin
        result_o.scl_release = 1'b0;
        result_o.sda_release = 1'b0;
        state_o.phase        = PH_STOP2;
      end
      PH_STOP2: begin
        result_o.sda_release = 1'b0;
        state_o.phase        = PH_STOP3;
      end
      PH_STOP3: begin
        if (state_i.error_code == STAT_OK && state_i.held_mode == MODE_RD &&
            state_i.stage == STG_SECOND) begin
          state_o.phase = PH_CHECK;
        end else begin
          result_o.done   = 1'b1;
          result_o.status = state_i.error_code;
          state_o.phase   = PH_IDLE;
        end
      end
      default: begin
        result_o.done = 1'b1;
        state_o.phase = PH_IDLE;
      end
    endcase

    result_o.busy = (state_o.phase != PH_IDLE);
  end

endmodule

// File: sim/tb_sccb_register_master_core.sv
`timescale 1ns / 1ps
// tb_sccb_register_master_core: self-checking bench for the SCCB register master.
// Mirrors the bus phase sequencer tick by tick and compares every output item.
// Depends on sccbm_pkg and sccb_register_master_core.
module tb_sccb_register_master_core;
  import sccbm_pkg::*;

  localparam int BURST_CAP    = 256;
  localparam int RANDOM_ITEMS = 1250;
  localparam int HOLD_LEN     = 80;   // long receiver hold-off, in cycles
  localparam int CFG_EVERY    = 250;  // random phase re-programs the address this often

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // how the emulated device misbehaves during one transfer
  typedef enum logic [1:0] {
    FLT_NONE,
    FLT_BUSY_CHECK,  // data line held low when the master checks the bus
    FLT_BUSY_HOLD,   // data line not low after the start condition
    FLT_NACK         // device leaves the acknowledge bit high
  } fault_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  reg_offset;
    logic [15:0] write_data;
    logic        write_two;
    logic [8:0]  read_count;
    logic        sda;
  } tick_t;

  // ---------------------------------------------------------------- DUT ports
  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i         = '0;
  logic [7:0]  reg_offset_i  = '0;
  logic [15:0] write_data_i  = '0;
  logic        write_two_i   = 1'b0;
  logic [8:0]  read_count_i  = '0;
  logic        sda_sample_i  = 1'b1;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic        scl_release_o;
  logic        sda_release_o;
  logic [7:0]  read_byte_o;
  logic        byte_valid_o;
  logic        last_byte_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic [1:0]  status_o;

  sccb_register_master_core #(.MAX_BURST(BURST_CAP)) dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .cmd_i, .reg_offset_i, .write_data_i, .write_two_i,
    .read_count_i, .sda_sample_i,
    .out_valid_o, .out_stall_i, .scl_release_o, .sda_release_o, .read_byte_o,
    .byte_valid_o, .last_byte_o, .busy_res_o, .done_res_o, .status_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ------------------------------------------------------- sequencer mirror
  logic [6:0]  dev_addr = 7'd33;
  logic [3:0]  bus_phase = PH_IDLE;
  logic [3:0]  bits_to_go = '0;
  logic [7:0]  shifter = '0;
  logic [8:0]  burst_left = '0;
  logic [7:0]  latched_offset = '0;
  logic [15:0] latched_data = '0;
  logic [1:0]  latched_mode = MODE_NONE;
  logic [1:0]  fail_code = STAT_OK;
  logic [1:0]  byte_stage = STG_ADDR;

  result_t pin_status_q[$];   // pin levels and status still to come out

  int unsigned mismatches     = 0;
  int unsigned items_sent     = 0;
  int unsigned transfer_ticks = 0;
  int unsigned results_seen   = 0;
  int unsigned transfers_done = 0;
  int unsigned bytes_read     = 0;

  function automatic void load_shifter(input logic [7:0] b);
    shifter    = b;
    bits_to_go = BYTE_BITS;
    bus_phase  = PH_BIT_LOW;
  endfunction

  // One bus phase tick: advances the mirrored state, returns the item it yields.
  function automatic result_t step_bus_phase(input tick_t t);
    result_t r;
    r = '0;
    r.scl_release = 1'b1;
    r.sda_release = 1'b1;
    case (bus_phase)
      PH_IDLE: begin
        // anything but a start command (the unused code too) just ticks
        if (t.cmd == CMD_WRITE || t.cmd == CMD_READ) begin
          latched_offset = t.reg_offset;
          latched_data   = t.write_data;
          if (t.cmd == CMD_WRITE) begin
            latched_mode = t.write_two ? MODE_W16 : MODE_W8;
            burst_left   = '0;
          end else begin
            latched_mode = MODE_RD;
            burst_left   = (t.read_count > BURST_CAP) ? 9'(BURST_CAP) : t.read_count;
          end
          fail_code  = STAT_OK;
          byte_stage = STG_ADDR;
          bus_phase  = PH_CHECK;
        end
      end
      PH_CHECK: begin
        // bus must be free; a failure ends the transfer without a stop
        if (!t.sda) begin
          r.done    = 1'b1;
          r.status  = STAT_BUS_BUSY;
          bus_phase = PH_IDLE;
        end else begin
          bus_phase = PH_START;
        end
      end
      PH_START: begin
        r.sda_release = 1'b0;
        bus_phase     = PH_START_HOLD;
      end
      PH_START_HOLD: begin
        r.scl_release = 1'b0;
        r.sda_release = 1'b0;
        if (t.sda) begin
          r.done    = 1'b1;
          r.status  = STAT_BUS_BUSY;
          bus_phase = PH_IDLE;
        end else begin
          // R/W bit is set only for the address after the restart
          load_shifter({dev_addr, byte_stage == STG_SECOND});
        end
      end
      PH_BIT_LOW: begin
        r.scl_release = 1'b0;
        r.sda_release = shifter[7];
        bus_phase     = PH_BIT_HIGH;
      end
      PH_BIT_HIGH: begin
        r.sda_release = shifter[7];
        shifter       = shifter << 1;
        bits_to_go    = bits_to_go - 4'd1;
        bus_phase     = (bits_to_go == '0) ? PH_ACK_LOW : PH_BIT_LOW;
      end
      PH_ACK_LOW: begin
        r.scl_release = 1'b0;
        bus_phase     = PH_ACK_HIGH;
      end
      PH_ACK_HIGH: begin
        if (t.sda) begin
          fail_code = STAT_NACK;
          bus_phase = PH_STOP1;
        end else if (byte_stage == STG_ADDR) begin
          byte_stage = STG_OFFSET;
          load_shifter(latched_offset);
        end else if (latched_mode == MODE_RD) begin
          if (byte_stage == STG_OFFSET) begin
            byte_stage = STG_SECOND;   // stop, then restart for the read address
            bus_phase  = PH_STOP1;
          end else begin
            byte_stage = STG_THIRD;
            bits_to_go = BYTE_BITS;
            shifter    = '0;
            // an empty burst stops straight away and reports ok
            bus_phase  = (burst_left == '0) ? PH_STOP1 : PH_RD_LOW;
          end
        end else if (byte_stage == STG_OFFSET) begin
          byte_stage = STG_SECOND;
          load_shifter(latched_mode == MODE_W16 ? latched_data[15:8] : latched_data[7:0]);
        end else if (byte_stage == STG_SECOND && latched_mode == MODE_W16) begin
          byte_stage = STG_THIRD;
          load_shifter(latched_data[7:0]);
        end else begin
          bus_phase = PH_STOP1;
        end
      end
      PH_RD_LOW: begin
        r.scl_release = 1'b0;
        bus_phase     = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin
        shifter    = {shifter[6:0], t.sda};
        bits_to_go = bits_to_go - 4'd1;
        if (bits_to_go == '0) begin
          r.byte_valid = 1'b1;
          r.read_byte  = shifter;
          r.last_byte  = (burst_left == 9'd1);
          bus_phase    = PH_MACK_LOW;
          bytes_read++;
        end else begin
          bus_phase = PH_RD_LOW;
        end
      end
      PH_MACK_LOW: begin
        r.scl_release = 1'b0;
        r.sda_release = (burst_left <= 9'd1);   // NACK on the last byte
        bus_phase     = PH_MACK_HIGH;
      end
      PH_MACK_HIGH: begin
        r.sda_release = (burst_left <= 9'd1);
        if (burst_left != '0) burst_left = burst_left - 9'd1;
        if (burst_left == '0) begin
          bus_phase = PH_STOP1;
        end else begin
          bits_to_go = BYTE_BITS;
          shifter    = '0;
          bus_phase  = PH_RD_LOW;
        end
      end
      PH_STOP1: begin
        r.scl_release = 1'b0;
        r.sda_release = 1'b0;
        bus_phase     = PH_STOP2;
      end
      PH_STOP2: begin
        r.sda_release = 1'b0;
        bus_phase     = PH_STOP3;
      end
      default: begin
        if (bus_phase == PH_STOP3 && fail_code == STAT_OK && latched_mode == MODE_RD &&
            byte_stage == STG_SECOND) begin
          bus_phase = PH_CHECK;
        end else begin
          r.done    = 1'b1;
          r.status  = (bus_phase == PH_STOP3) ? fail_code : STAT_OK;
          bus_phase = PH_IDLE;
        end
      end
    endcase
    r.busy = (bus_phase != PH_IDLE);
    if (r.done) transfers_done++;
    return r;
  endfunction

  // ------------------------------------------------------------- checking
  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns %s: expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pin_status_q.size() == 0) begin
        mismatches++;
        $display("%0t ns unexpected item: expected none, got scl %b sda %b done %b",
                 $time, scl_release_o, sda_release_o, done_res_o);
      end else begin
        want = pin_status_q.pop_front();
        check_field("scl_release", want.scl_release, scl_release_o);
        check_field("sda_release", want.sda_release, sda_release_o);
        check_field("read_byte", want.read_byte, read_byte_o);
        check_field("byte_valid", want.byte_valid, byte_valid_o);
        check_field("last_byte", want.last_byte, last_byte_o);
        check_field("busy_res", want.busy, busy_res_o);
        check_field("done_res", want.done, done_res_o);
        check_field("status", want.status, status_o);
      end
    end
  end

  // ------------------------------------------------------------- receiver
  // Stall pattern of its own, in random stretches; a hold request from the
  // sequence gets a long hold-off counted here.
  int unsigned hold_token  = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_mode  = 0;
  int unsigned mode_left   = 0;
  int unsigned stall_count = 0;

  always @(posedge clk_i) begin
    stall_count++;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_served != hold_token) begin
      hold_served = hold_token;
      hold_left   = HOLD_LEN - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= (stall_count % 3 == 0);
        default: out_stall_i <= ($urandom_range(0, 9) < 6);
      endcase
    end
  end

  // --------------------------------------------------------------- sender
  logic        offering      = 1'b0;
  logic        sender_steady = 1'b0;
  int unsigned burst_run     = 0;

  function automatic tick_t noise_tick();
    tick_t t;
    t.cmd        = 2'($urandom_range(0, 3));
    t.reg_offset = 8'($urandom);
    t.write_data = 16'($urandom);
    t.write_two  = 1'($urandom);
    t.read_count = 9'($urandom);
    t.sda        = 1'($urandom);
    return t;
  endfunction

  // Offers one item, waits for it to be taken, then records its result.
  task automatic send_tick(input tick_t t);
    in_valid_i   <= 1'b1;
    offering     = 1'b1;
    cmd_i        <= t.cmd;
    reg_offset_i <= t.reg_offset;
    write_data_i <= t.write_data;
    write_two_i  <= t.write_two;
    read_count_i <= t.read_count;
    sda_sample_i <= t.sda;
    do @(posedge clk_i); while (in_stall_o);
    pin_status_q.push_back(step_bus_phase(t));
    items_sent++;
    if (!sender_steady) begin
      if (burst_run != 0) begin
        burst_run--;
      end else begin
        burst_run  = $urandom_range(0, 24);
        in_valid_i <= 1'b0;
        offering   = 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering   = 1'b0;
    end
    while (pin_status_q.size() != 0) @(posedge clk_i);
  endtask

  // One whole transfer: the start command, then device-like ticks until idle.
  // Commands offered while busy are random and must be ignored.
  task automatic run_transfer(input logic [1:0] cmd, input logic [7:0] off,
                              input logic [15:0] data, input logic two,
                              input logic [8:0] cnt, input fault_t flt, input int flt_at);
    tick_t t;
    int    n_check;
    int    n_hold;
    int    n_ack;
    n_check      = 0;
    n_hold       = 0;
    n_ack        = 0;
    t            = noise_tick();
    t.cmd        = cmd;
    t.reg_offset = off;
    t.write_data = data;
    t.write_two  = two;
    t.read_count = cnt;
    send_tick(t);
    transfer_ticks++;
    while (bus_phase != PH_IDLE) begin
      t = noise_tick();
      case (bus_phase)
        PH_CHECK: begin
          t.sda = !(flt == FLT_BUSY_CHECK && n_check == flt_at);
          n_check++;
        end
        PH_START_HOLD: begin
          t.sda = (flt == FLT_BUSY_HOLD && n_hold == flt_at);
          n_hold++;
        end
        PH_ACK_HIGH: begin
          t.sda = (flt == FLT_NACK && n_ack == flt_at);
          n_ack++;
        end
        default: ;   // read data and don't-care phases keep random levels
      endcase
      send_tick(t);
      transfer_ticks++;
    end
  endtask

  // ----------------------------------------------------- configuration port
  task automatic apb_access(input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_SLAVE;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    if (wr) dev_addr = wdata[6:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_slave_address();
    logic [31:0] rd;
    apb_access(1'b0, '0, rd);
    check_field("slave_address", dev_addr, rd[6:0]);
  endtask

  // only written with the block idle and every result back
  task automatic program_slave_address(input logic [31:0] val);
    logic [31:0] rd;
    drain_results();
    apb_access(1'b1, val, rd);
    check_slave_address();
  endtask

  // ------------------------------------------------------------------ tests
  task automatic test_reset_value();
    check_slave_address();
    run_transfer(CMD_WRITE, 8'h12, 16'h0034, 1'b0, '0, FLT_NONE, 0);
  endtask

  task automatic test_writes();
    program_slave_address(32'hFFFF_FFFF);
    run_transfer(CMD_WRITE, 8'hFF, 16'hFFFF, 1'b0, 9'h1FF, FLT_NONE, 0);
    run_transfer(CMD_WRITE, 8'h00, 16'h0000, 1'b1, '0, FLT_NONE, 0);
    program_slave_address(32'h0000_0000);
    run_transfer(CMD_WRITE, 8'hA5, 16'hC35A, 1'b1, '0, FLT_NONE, 0);
    run_transfer(CMD_WRITE, 8'h5A, 16'hFF00, 1'b0, '0, FLT_NONE, 0);
  endtask

  task automatic test_reads();
    run_transfer(CMD_READ, 8'hFF, 16'hFFFF, 1'b1, 9'd1, FLT_NONE, 0);
    program_slave_address(32'h0000_007F);
    run_transfer(CMD_READ, 8'h00, 16'h0000, 1'b0, 9'd2, FLT_NONE, 0);
    run_transfer(CMD_READ, 8'h3C, 16'h1234, 1'b0, 9'd3, FLT_NONE, 0);
  endtask

  task automatic test_empty_read();
    run_transfer(CMD_READ, 8'h81, 16'h0000, 1'b0, 9'd0, FLT_NONE, 0);
  endtask

  // count above the cap: the burst is clamped
  task automatic test_long_read();
    program_slave_address(32'd33);
    run_transfer(CMD_READ, 8'h7E, 16'hAAAA, 1'b1, 9'h1FF, FLT_NONE, 0);
  endtask

  task automatic test_bus_busy();
    run_transfer(CMD_WRITE, 8'h10, 16'h1111, 1'b1, '0, FLT_BUSY_CHECK, 0);
    run_transfer(CMD_WRITE, 8'h20, 16'h2222, 1'b0, '0, FLT_BUSY_HOLD, 0);
    // same checks around the restart of a read
    run_transfer(CMD_READ, 8'h30, 16'h3333, 1'b0, 9'd2, FLT_BUSY_CHECK, 1);
    run_transfer(CMD_READ, 8'h40, 16'h4444, 1'b0, 9'd2, FLT_BUSY_HOLD, 1);
  endtask

  task automatic test_no_ack();
    run_transfer(CMD_WRITE, 8'h01, 16'h0102, 1'b1, '0, FLT_NACK, 0);
    run_transfer(CMD_WRITE, 8'h02, 16'h0304, 1'b1, '0, FLT_NACK, 1);
    run_transfer(CMD_WRITE, 8'h03, 16'h0506, 1'b1, '0, FLT_NACK, 2);
    run_transfer(CMD_WRITE, 8'h04, 16'h0708, 1'b1, '0, FLT_NACK, 3);
    run_transfer(CMD_READ, 8'h05, 16'h090A, 1'b0, 9'd2, FLT_NACK, 2);
  endtask

  task automatic test_idle_commands();
    tick_t t;
    t     = noise_tick();
    t.cmd = CMD_UNUSED;
    send_tick(t);
    t     = noise_tick();
    t.cmd = CMD_TICK;
    send_tick(t);
    t     = noise_tick();
    t.cmd = CMD_UNUSED;
    send_tick(t);
  endtask

  // Receiver holds off while the sender keeps offering, then the sender
  // waits for the block to empty.
  task automatic test_backpressure();
    hold_token++;
    sender_steady = 1'b1;
    run_transfer(CMD_WRITE, 8'hC3, 16'hBEEF, 1'b1, '0, FLT_NONE, 0);
    sender_steady = 1'b0;
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned start_ticks;
    int unsigned next_cfg;
    int unsigned pick;
    logic [31:0] cfg;
    logic [8:0]  cnt;
    fault_t      flt;
    tick_t       t;
    start_ticks = transfer_ticks;
    next_cfg    = transfer_ticks + CFG_EVERY;
    while (transfer_ticks - start_ticks < RANDOM_ITEMS) begin
      if (transfer_ticks >= next_cfg) begin
        cfg = $urandom;
        pick = $urandom_range(0, 3);
        if (pick == 0) cfg[6:0] = '0;
        else if (pick == 1) cfg[6:0] = '1;
        program_slave_address(cfg);
        next_cfg = transfer_ticks + CFG_EVERY;
      end
      sender_steady = ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        repeat ($urandom_range(1, 4)) begin
          t     = noise_tick();
          t.cmd = $urandom_range(0, 1) ? CMD_TICK : CMD_UNUSED;
          send_tick(t);
        end
      end else begin
        flt = (pick < 7) ? FLT_NONE : fault_t'($urandom_range(1, 3));
        cnt = ($urandom_range(0, 19) < 14) ? 9'($urandom_range(0, 4))
                                            : 9'($urandom_range(5, 20));
        run_transfer($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 8'($urandom),
                     16'($urandom), 1'($urandom), cnt, flt, $urandom_range(0, 3));
      end
    end
    sender_steady = 1'b0;
  endtask

  // -------------------------------------------------------------- sequence
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_value();
    test_writes();
    test_reads();
    test_empty_read();
    test_long_read();
    test_bus_busy();
    test_no_ack();
    test_idle_commands();
    test_backpressure();
    test_random_traffic();
    drain_results();
    repeat (4) @(posedge clk_i);
    $display("Covered %0d ticks, %0d items checked, %0d transfers, %0d bytes read,",
             items_sent, results_seen, transfers_done, bytes_read);
    $display("with writes, bursts, bus-busy and missing-ack aborts; %0d mismatches",
             mismatches);
    if (mismatches == 0 && pin_status_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sccb_register_master_core.f
rtl/core/sccbm_pkg.sv
rtl/core/sccbm_step.sv
rtl/core/sccb_register_master_core.sv
sim/tb_sccb_register_master_core.sv
